// ===== hdl/ppa_pkg.sv =====
// ============================================================================
// ppa_pkg : shared types and constants for the progressive pixel accumulator
// Item layouts on both channels, the divider hand-off item and field widths.
// ============================================================================
package ppa_pkg;

    localparam int INDEX_W  = 16;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 32;
    localparam int COUNT_W  = 16;
    localparam int BYTE_W   = 8;
    localparam int CHANNELS = 4;

    localparam int DEFAULT_PIXELS            = 65536;
    localparam int DEFAULT_CHANNEL_FRAC_BITS = 8;

    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [BYTE_W-1:0]  BYTE_MAX  = '1;

    // One rendered sample
    typedef struct packed {
        logic [INDEX_W-1:0]  pixel_index;
        logic [SAMPLE_W-1:0] sample_red;
        logic [SAMPLE_W-1:0] sample_green;
        logic [SAMPLE_W-1:0] sample_blue;
        logic [SAMPLE_W-1:0] sample_alpha;
        logic                frame_end;
    } sample_t;

    // One averaged pixel
    typedef struct packed {
        logic [INDEX_W-1:0]       out_index;
        logic [CHANNELS*BYTE_W-1:0] packed_rgba;
    } result_t;

    // Channel sums, red in slot 0 up to alpha in slot 3
    typedef logic [CHANNELS-1:0][SUM_W-1:0] sums_t;

    // Item handed from the store update to the divider
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [COUNT_W-1:0] frames;
        sums_t              sums;
    } div_item_t;

endpackage

// ===== hdl/ppa_byte_div.sv =====
// ============================================================================
// ppa_byte_div : pipelined average-to-byte divider
// Turns four channel sums into bytes, floor(sum * 255 / (frames << frac)),
// clamped to 255. One quotient bit per stage, one item per cycle if unstalled.
// ============================================================================
module ppa_byte_div #(
    parameter int CHANNEL_FRAC_BITS = ppa_pkg::DEFAULT_CHANNEL_FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ppa_pkg::div_item_t  div_item,
    input  logic                div_valid,
    output logic                div_ready,
    output ppa_pkg::result_t    result,
    output logic                result_valid,
    input  logic                result_ready
);
    import ppa_pkg::*;

    localparam int DIV_W  = COUNT_W + CHANNEL_FRAC_BITS;
    localparam int REM_W  = DIV_W + BYTE_W;
    localparam int STAGES = BYTE_W;

    logic [STAGES:0]     v_reg;
    logic [STAGES+1:0]   go;
    logic [INDEX_W-1:0]  idx_reg [STAGES+1];
    logic [DIV_W-1:0]    den_reg [STAGES+1];
    logic [CHANNELS-1:0] sat_reg [STAGES+1];
    logic [REM_W-1:0]    rem_reg [STAGES+1][CHANNELS];
    logic [BYTE_W-1:0]   quo_reg [STAGES+1][CHANNELS];

    logic [DIV_W-1:0]    den_next;
    logic [CHANNELS-1:0] sat_next;
    logic [REM_W-1:0]    rem_next [STAGES+1][CHANNELS];
    logic [BYTE_W-1:0]   quo_next [STAGES+1][CHANNELS];

    // Stage s may load when it is empty or its item moves on
    always_comb
    begin
        go[STAGES+1] = result_ready;
        for (int s = STAGES; s >= 0; s--)
        begin
            go[s] = !v_reg[s] || go[s+1];
        end
    end

    assign div_ready = go[0];

    // Entry stage: divisor, clamp test and numerator sum * 255;
    // then long-division steps, most significant quotient bit first
    always_comb
    begin
        logic [COUNT_W-1:0] frames_eff;
        logic [DIV_W-1:0]   sum_lo;
        logic [REM_W-1:0]   trial;
        frames_eff = (div_item.frames == '0) ? COUNT_ONE : div_item.frames;
        den_next   = DIV_W'(frames_eff) << CHANNEL_FRAC_BITS;
        for (int c = 0; c < CHANNELS; c++)
        begin
            sum_lo         = div_item.sums[c][DIV_W-1:0];
            sat_next[c]    = div_item.sums[c] >= SUM_W'(den_next);
            rem_next[0][c] = (REM_W'(sum_lo) << BYTE_W) - REM_W'(sum_lo);
            quo_next[0][c] = '0;
        end
        for (int s = 1; s <= STAGES; s++)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                trial          = REM_W'(den_reg[s-1]) << (STAGES - s);
                rem_next[s][c] = rem_reg[s-1][c];
                quo_next[s][c] = quo_reg[s-1][c];
                if (rem_reg[s-1][c] >= trial)
                begin
                    rem_next[s][c]              = rem_reg[s-1][c] - trial;
                    quo_next[s][c][STAGES - s]  = 1'b1;
                end
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (go[0])
            begin
                v_reg[0] <= div_valid;
            end
            for (int s = 1; s <= STAGES; s++)
            begin
                if (go[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (go[0])
        begin
            idx_reg[0] <= div_item.index;
            den_reg[0] <= den_next;
            sat_reg[0] <= sat_next;
            rem_reg[0] <= rem_next[0];
            quo_reg[0] <= quo_next[0];
        end
        for (int s = 1; s <= STAGES; s++)
        begin
            if (go[s])
            begin
                idx_reg[s] <= idx_reg[s-1];
                den_reg[s] <= den_reg[s-1];
                sat_reg[s] <= sat_reg[s-1];
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
            end
        end
    end

    // Pack bytes, alpha on top, red at the bottom
    always_comb
    begin
        result.out_index = idx_reg[STAGES];
        for (int c = 0; c < CHANNELS; c++)
        begin
            result.packed_rgba[c*BYTE_W +: BYTE_W] =
                sat_reg[STAGES][c] ? BYTE_MAX : quo_reg[STAGES][c];
        end
    end

    assign result_valid = v_reg[STAGES];

endmodule

// ===== hdl/progressive_pixel_accumulator.sv =====
// ============================================================================
// progressive_pixel_accumulator : per-pixel frame accumulation and averaging
// Adds each sample into its pixel's store entry and returns the average over
// the frames seen so far, clamped and packed as four bytes.
// ============================================================================
//
//  Channel | Handshake                    | Payload            | Role
//  --------+------------------------------+--------------------+----------------
//  sample  | sample_valid / sample_ready  | ppa_pkg::sample_t  | pixel samples
//  result  | result_valid / result_ready  | ppa_pkg::result_t  | packed averages
//
//  One item per cycle while result_ready stays high; each result passes the
//  store read, read-modify-write, then a nine-stage divider.
//  The store is read on accept and written back as the item moves on; a
//  back-to-back hit on the same pixel takes the sum from the write-back stage.
//  Reset sets the frame count to one; the store needs no clearing, since
//  frame one ignores its contents.
//  Stalls on the result side fill empty stages first; sample_ready drops only
//  when every stage holds an item.
//
module progressive_pixel_accumulator #(
    parameter int PIXELS            = ppa_pkg::DEFAULT_PIXELS,
    parameter int CHANNEL_FRAC_BITS = ppa_pkg::DEFAULT_CHANNEL_FRAC_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ppa_pkg::sample_t  sample,
    input  logic              sample_valid,
    output logic              sample_ready,
    output ppa_pkg::result_t  result,
    output logic              result_valid,
    input  logic              result_ready
);
    import ppa_pkg::*;

    localparam int SPAN        = 1 << INDEX_W;
    localparam int STORE_DEPTH = (PIXELS < SPAN) ? PIXELS : SPAN;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Accumulation store
    sums_t store_mem [STORE_DEPTH];
    sums_t rd_data_reg;

    logic [COUNT_W-1:0] frame_count_reg;

    // Read stage
    logic               s1_v_reg;
    sample_t            s1_item_reg;
    logic               s1_first_reg;
    logic               s1_inr_reg;
    logic [COUNT_W-1:0] s1_frames_reg;

    // Write-back stage
    logic               s2_v_reg;
    logic [INDEX_W-1:0] s2_index_reg;
    logic               s2_inr_reg;
    logic [COUNT_W-1:0] s2_frames_reg;
    sums_t              s2_sums_reg;

    logic      go1;
    logic      go2;
    logic      accept;
    logic      in_range;
    logic      fwd;
    logic      div_ready;
    sums_t     old_sums;
    sums_t     sums_next;
    div_item_t div_item;
    logic [CHANNELS-1:0][SAMPLE_W-1:0] s1_samples;

    // Handshake and stage enables
    assign go2          = !s2_v_reg || div_ready;
    assign go1          = !s1_v_reg || go2;
    assign sample_ready = go1;
    assign accept       = sample_valid && sample_ready;
    assign in_range     = 32'(sample.pixel_index) < 32'(PIXELS);

    // Frame count, read-stage and write-back-stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= COUNT_ONE;
            s1_v_reg        <= 1'b0;
            s2_v_reg        <= 1'b0;
        end
        else
        begin
            if (accept && sample.frame_end && frame_count_reg != COUNT_MAX)
            begin
                frame_count_reg <= frame_count_reg + COUNT_ONE;
            end
            if (go1)
            begin
                s1_v_reg <= accept;
            end
            if (go2)
            begin
                s2_v_reg <= s1_v_reg;
            end
        end
    end

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg   <= sample;
            s1_first_reg  <= (frame_count_reg == COUNT_ONE);
            s1_inr_reg    <= in_range;
            s1_frames_reg <= frame_count_reg;
        end
    end

    // Store port: read on accept, write back when the item moves on
    always_ff @(posedge clk)
    begin
        if (s1_v_reg && s1_inr_reg && go2)
        begin
            store_mem[s1_item_reg.pixel_index[ADDR_W-1:0]] <= sums_next;
        end
        if (accept)
        begin
            rd_data_reg <= store_mem[sample.pixel_index[ADDR_W-1:0]];
        end
    end

    // Pick the old sums: zero in frame one or beyond the store, forwarded on a
    // back-to-back hit
    assign fwd = s2_v_reg && s2_inr_reg && s1_inr_reg
              && (s2_index_reg == s1_item_reg.pixel_index);

    always_comb
    begin
        if (s1_first_reg || !s1_inr_reg)
        begin
            old_sums = '0;
        end
        else if (fwd)
        begin
            old_sums = s2_sums_reg;
        end
        else
        begin
            old_sums = rd_data_reg;
        end
    end

    // Add samples with saturation
    assign s1_samples[0] = s1_item_reg.sample_red;
    assign s1_samples[1] = s1_item_reg.sample_green;
    assign s1_samples[2] = s1_item_reg.sample_blue;
    assign s1_samples[3] = s1_item_reg.sample_alpha;

    always_comb
    begin
        logic [SUM_W:0] wide;
        for (int c = 0; c < CHANNELS; c++)
        begin
            wide         = {1'b0, old_sums[c]} + (SUM_W+1)'(s1_samples[c]);
            sums_next[c] = wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
        end
    end

    // Hold the new sums for the divider and for forwarding
    always_ff @(posedge clk)
    begin
        if (go2)
        begin
            s2_index_reg  <= s1_item_reg.pixel_index;
            s2_inr_reg    <= s1_inr_reg;
            s2_frames_reg <= s1_frames_reg;
            s2_sums_reg   <= sums_next;
        end
    end

    assign div_item.index  = s2_index_reg;
    assign div_item.frames = s2_frames_reg;
    assign div_item.sums   = s2_sums_reg;

    ppa_byte_div #(
        .CHANNEL_FRAC_BITS (CHANNEL_FRAC_BITS)
    ) u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .div_item     (div_item),
        .div_valid    (s2_v_reg),
        .div_ready    (div_ready),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    // Checks
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        frame_count_reg != '0)
        else $error("frame count reached zero");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sample.frame_end && frame_count_reg != COUNT_MAX)
        |=> frame_count_reg == COUNT_W'($past(frame_count_reg) + COUNT_ONE))
        else $error("frame count did not advance on frame end");

    a_fwd_source_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_v_reg && !go2) |=> (s2_v_reg && $stable(s2_sums_reg)
                                && $stable(s2_index_reg)))
        else $error("write-back stage changed under a stalled read stage");

    a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_v_reg |-> sample_ready)
        else $error("sample refused with read stage empty");

endmodule

// ===== test/progressive_pixel_accumulator_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// progressive_pixel_accumulator_test : self-checking bench for the accumulator
// Drives pixel samples through the valid/ready sample channel and checks every
// packed average against a behavioural predictor of the accumulation store
// and frame counter. A short table of hand-worked samples opens the run; then
// random frames (frame one on any pixel, then on written ones), back-pressure,
// sender pauses and a closing single-pixel run that ends a frame on every item.
// ============================================================================
module progressive_pixel_accumulator_test;

    import ppa_pkg::*;

    localparam int FRAC_BITS         = DEFAULT_CHANNEL_FRAC_BITS;
    localparam int RANDOM_ITEMS      = 1600;
    localparam int FIRST_FRAME_ITEMS = 300;
    localparam int LONG_RUN_ITEMS    = 140;
    localparam int BACKLOG_CYCLES    = 200;
    localparam int STALL_LIMIT       = 5000;
    localparam int TAIL_CYCLES       = 20;
    localparam int REPORT_LIMIT      = 10;

    // One row of the hand-worked table; rgba is used only where typed is set
    typedef struct {
        sample_t                    item;
        bit                         typed;
        logic [CHANNELS*BYTE_W-1:0] rgba;
    } stim_row_t;

    logic    clk;
    logic    rst_n        = 1'b0;
    sample_t sample       = '0;
    logic    sample_valid = 1'b0;
    logic    sample_ready;
    result_t result;
    logic    result_valid;
    logic    result_ready = 1'b0;

    // Predictor state: running channel sums per written pixel and frame number
    sums_t              pixel_sums [bit [INDEX_W-1:0]];
    bit [INDEX_W-1:0]   known_pixels [$];
    logic [COUNT_W-1:0] frame_number = COUNT_ONE;
    logic [INDEX_W-1:0] last_index   = '0;

    result_t   expected_pixels [$];
    stim_row_t directed_rows [$];
    int        mismatches     = 0;
    int        stalled_cycles = 0;
    bit        steady_stream  = 1'b0;
    bit        backlog_req    = 1'b0;

    progressive_pixel_accumulator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Add one sample into its pixel and return the averaged, packed bytes
    function automatic result_t accumulate_pixel(input sample_t s);
        result_t                      avg;
        sums_t                        old_sums;
        sums_t                        new_sums;
        logic [CHANNELS-1:0][SAMPLE_W-1:0] level;
        logic [SUM_W:0]               wide;
        logic [63:0]                  full_scale;
        full_scale = 64'(frame_number) << FRAC_BITS;
        level      = {s.sample_alpha, s.sample_blue, s.sample_green, s.sample_red};
        old_sums   = '0;
        if (!pixel_sums.exists(s.pixel_index))
            known_pixels.push_back(s.pixel_index);
        else if (frame_number != COUNT_ONE)
            old_sums = pixel_sums[s.pixel_index];
        avg.out_index = s.pixel_index;
        for (int c = 0; c < CHANNELS; c++)
        begin
            wide        = {1'b0, old_sums[c]} + (SUM_W+1)'(level[c]);
            new_sums[c] = wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
            // clamp at 1.0, otherwise scale by 255 and truncate once
            if (64'(new_sums[c]) >= full_scale)
                avg.packed_rgba[BYTE_W*c +: BYTE_W] = BYTE_MAX;
            else
                avg.packed_rgba[BYTE_W*c +: BYTE_W] =
                    BYTE_W'((64'(new_sums[c]) * 64'd255) / full_scale);
        end
        pixel_sums[s.pixel_index] = new_sums;
        last_index                = s.pixel_index;
        if (s.frame_end && frame_number != COUNT_MAX)
            frame_number = frame_number + COUNT_W'(1);
        return avg;
    endfunction

    function automatic stim_row_t make_row(input logic [15:0] idx, input logic [15:0] r,
                                           input logic [15:0] g, input logic [15:0] b,
                                           input logic [15:0] a, input bit typed,
                                           input logic [31:0] rgba);
        stim_row_t row;
        row.item  = '{idx, r, g, b, a, 1'b0};
        row.typed = typed;
        row.rgba  = rgba;
        return row;
    endfunction

    // Random sample: any pixel in frame one, afterwards only pixels already written
    function automatic sample_t draw_sample(input bit closes_frame);
        sample_t s;
        logic [CHANNELS-1:0][SAMPLE_W-1:0] level;
        for (int c = 0; c < CHANNELS; c++)
            level[c] = ($urandom_range(99) < 60) ? SAMPLE_W'($urandom_range(0, 'h3FF))
                                                 : SAMPLE_W'($urandom);
        if ($urandom_range(7) == 0)
            s.pixel_index = last_index;
        else if (frame_number == COUNT_ONE)
            s.pixel_index = INDEX_W'($urandom);
        else
            s.pixel_index = known_pixels[$urandom_range(0, known_pixels.size() - 1)];
        s.sample_red   = level[0];
        s.sample_green = level[1];
        s.sample_blue  = level[2];
        s.sample_alpha = level[3];
        s.frame_end    = closes_frame;
        return s;
    endfunction

    // Offer one item from a falling edge, hold it until taken, then predict
    task automatic offer_sample(input sample_t s, input bit typed,
                                input logic [31:0] rgba);
        result_t avg;
        while (!steady_stream && $urandom_range(99) < 30)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample       <= s;
        sample_valid <= 1'b1;
        do
            @(posedge clk);
        while (!sample_ready);
        avg = accumulate_pixel(s);
        if (typed)
            avg.packed_rgba = rgba;
        expected_pixels.push_back(avg);
        @(negedge clk);
    endtask

    // Drop valid and wait for every pending result to arrive
    task automatic drain_results();
        sample_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // Receiver: random ready, with one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (backlog_req)
            begin
                result_ready <= 1'b0;
                repeat (BACKLOG_CYCLES) @(negedge clk);
                backlog_req = 1'b0;
            end
            result_ready <= steady_stream || ($urandom_range(99) >= 30);
            @(negedge clk);
        end
    end

    // Compare each accepted result with the oldest pending one
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch("unexpected result", '0, result.packed_rgba);
            else
            begin
                want = expected_pixels.pop_front();
                if (result.out_index !== want.out_index)
                    report_mismatch("out_index", 32'(want.out_index), 32'(result.out_index));
                if (result.packed_rgba !== want.packed_rgba)
                    report_mismatch("packed_rgba", want.packed_rgba, result.packed_rgba);
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((sample_valid && sample_ready) || (result_valid && result_ready))
            stalled_cycles <= 0;
        else if (rst_n)
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        // Frame one rows: old sums ignored, so bytes follow from the sample alone
        directed_rows.push_back(make_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                         1'b1, 32'h0000_0000));
        directed_rows.push_back(make_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                         1'b1, 32'hFFFF_FFFF));
        directed_rows.push_back(make_row(16'h0100, 16'h0100, 16'h0080, 16'h0001, 16'h00FF,
                                         1'b1, 32'hFE00_7FFF));
        directed_rows.push_back(make_row(16'h00FF, 16'h0000, 16'hFFFF, 16'h0100, 16'h0000,
                                         1'b1, 32'h00FF_FF00));
        directed_rows.push_back(make_row(16'h8000, 16'h00FF, 16'h0101, 16'h00FE, 16'h0080,
                                         1'b1, 32'h7FFD_FFFE));
        directed_rows.push_back(make_row(16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0000,
                                         1'b1, 32'h0003_0201));
        // same pixel back to back: still frame one, so the earlier sum is ignored
        directed_rows.push_back(make_row(16'h0001, 16'h0004, 16'h0003, 16'h0002, 16'h0001,
                                         1'b1, 32'h0001_0203));
        directed_rows.push_back(make_row(16'h0001, 16'h0004, 16'h0003, 16'h0002, 16'h0001,
                                         1'b1, 32'h0001_0203));
        directed_rows.push_back(make_row(16'h5555, 16'h5555, 16'hAAAA, 16'h0000, 16'h0001,
                                         1'b1, 32'h0000_FFFF));
        directed_rows.push_back(make_row(16'hAAAA, 16'hAAAA, 16'h5555, 16'hFFFF, 16'h0100,
                                         1'b1, 32'hFFFF_FFFF));
        directed_rows.push_back(make_row(16'h7FFF, 16'h0080, 16'h0040, 16'h0020, 16'h0010,
                                         1'b1, 32'h0F1F_3F7F));
        directed_rows.push_back(make_row(16'h1234, 16'h0ABC, 16'h0123, 16'h0045, 16'h0006,
                                         1'b0, '0));
        directed_rows.push_back(make_row(16'h1234, 16'h00FF, 16'h8001, 16'h0000, 16'h7FFF,
                                         1'b0, '0));

        // Hold reset low, then release it on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer_sample(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].rgba);
        drain_results();

        // Random frames: populate frame one widely, then revisit written pixels
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady_stream = (n >= 900 && n < 1200);
            if (n == 600)
                backlog_req = 1'b1;
            if (n == 1400)
                drain_results();
            if (n < FIRST_FRAME_ITEMS)
                offer_sample(draw_sample(n == FIRST_FRAME_ITEMS - 1), 1'b0, '0);
            else
                offer_sample(draw_sample($urandom_range(39) == 0), 1'b0, '0);
        end
        steady_stream = 1'b0;

        // Closing run on one pixel: end a frame on every item
        for (int n = 0; n < LONG_RUN_ITEMS; n++)
            offer_sample('{16'h0000, 16'hFFFF, 16'hFFFF, SAMPLE_W'($urandom),
                           SAMPLE_W'($urandom_range(0, 'h3FF)), 1'b1}, 1'b0, '0);

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ppa_pkg.sv
hdl/ppa_byte_div.sv
hdl/progressive_pixel_accumulator.sv
test/progressive_pixel_accumulator_test.sv
